// ----- rtl/core/afp_pkg.sv -----
// ----------------------------------------------------------------------------
// afp_pkg: shared definitions for the AX.25 frame parser
// Request codes, result codes, header parse state and the FCS byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afp_pkg;

   // Default frame limits.
   localparam int MAX_FRAME_BYTES_DEF = 330;
   localparam int MIN_FRAME_BYTES_DEF = 18;
   localparam int MAX_REPEATERS_DEF   = 8;

   // Reflected CRC-16 (X.25): polynomial 0x1021 bit-reversed, all-ones seed.
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
   localparam logic [1:0]  CTRL_PID_MASK = 2'b11;
   localparam logic [6:0]  CHAR_SPACE = 7'h20;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_END   = 2'd2
   } afp_op_type;

   typedef enum logic [0:0] {
      KIND_INFO   = 1'b0,
      KIND_REPORT = 1'b1
   } afp_kind_type;

   typedef enum logic [1:0] {
      STAT_VALID     = 2'd0,
      STAT_SHORT     = 2'd1,
      STAT_TRUNCATED = 2'd2,
      STAT_FCS_BAD   = 2'd3
   } afp_status_type;

   typedef enum logic [2:0] {
      PH_DEST = 3'd0,
      PH_SRC  = 3'd1,
      PH_DIGI = 3'd2,
      PH_CTRL = 3'd3,
      PH_PID  = 3'd4,
      PH_DONE = 3'd5
   } afp_phase_type;

   // Header decode state carried from byte to byte.
   typedef struct packed {
      afp_phase_type phase;
      logic [2:0]    field_idx;
      logic          space_seen;
      logic          header_done;
      logic [8:0]    header_length;
      logic [47:0]   dest_call;
      logic [3:0]    dest_ssid;
      logic [47:0]   source_call;
      logic [3:0]    source_ssid;
      logic [3:0]    digi_count;
      logic [7:0]    control;
      logic [7:0]    pid;
   } afp_hdr_type;

   localparam afp_hdr_type HDR_CLEAR = '{
      phase:         PH_DEST,
      field_idx:     3'd0,
      space_seen:    1'b0,
      header_done:   1'b0,
      header_length: 9'd0,
      dest_call:     48'd0,
      dest_ssid:     4'd0,
      source_call:   48'd0,
      source_ssid:   4'd0,
      digi_count:    4'd0,
      control:       8'd0,
      pid:           8'd0
   };

   // One byte through the reflected CRC, least significant bit first.
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/afp_req_if.sv -----
// ----------------------------------------------------------------------------
// afp_req_if: request channel of the AX.25 frame parser
// Valid/ready channel carrying one frame control or data request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface afp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// ----- rtl/core/afp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// afp_rsp_if: result channel of the AX.25 frame parser
// Valid/ready channel carrying an info byte or an end-of-frame report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface afp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  info_byte;
   logic [1:0]  status;
   logic [47:0] dest_callsign;
   logic [3:0]  dest_ssid;
   logic [47:0] source_callsign;
   logic [3:0]  source_ssid;
   logic [3:0]  digipeater_count;
   logic [7:0]  control_byte;
   logic [7:0]  pid_byte;
   logic [8:0]  info_length;
   logic [15:0] received_fcs;

   modport source (output valid, output kind, output info_byte, output status,
                   output dest_callsign, output dest_ssid, output source_callsign,
                   output source_ssid, output digipeater_count, output control_byte,
                   output pid_byte, output info_length, output received_fcs,
                   input ready);
   modport sink   (input valid, input kind, input info_byte, input status,
                   input dest_callsign, input dest_ssid, input source_callsign,
                   input source_ssid, input digipeater_count, input control_byte,
                   input pid_byte, input info_length, input received_fcs,
                   output ready);
endinterface

// ----- rtl/core/afp_hdr_parse.sv -----
// ----------------------------------------------------------------------------
// afp_hdr_parse: AX.25 header decoder, one byte per step
// Advances the address, control and PID decode state by one frame byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afp_hdr_parse #(
   parameter int MAX_REPEATERS = afp_pkg::MAX_REPEATERS_DEF
) (
   input  afp_pkg::afp_hdr_type hdr_q,
   input  logic [7:0]           data_byte,
   input  logic [8:0]           byte_count,
   output afp_pkg::afp_hdr_type hdr_d
);
   import afp_pkg::*;

   localparam logic [3:0] MaxRep = 4'(MAX_REPEATERS);

   logic [6:0]  chr;
   logic        space_now;
   logic        addr_last;
   logic [47:0] call_in;
   logic [47:0] call_out;
   logic [3:0]  digi_next;
   logic        go_ctrl;

   assign chr       = data_byte[7:1];
   assign space_now = hdr_q.space_seen | (chr == CHAR_SPACE);
   assign addr_last = (hdr_q.field_idx >= 3'd6);
   assign call_in   = (hdr_q.phase == PH_SRC) ? hdr_q.source_call : hdr_q.dest_call;
   assign digi_next = hdr_q.digi_count + 4'd1;

   // Place the character in its lane; the first character lands in the top byte.
   always_comb begin
      call_out = call_in;
      for (int k = 0; k < 6; k++) begin
         if (hdr_q.field_idx == 3'(5 - k) && !space_now) begin
            call_out[8*k +: 8] = call_in[8*k +: 8] | {1'b0, chr};
         end
      end
   end

   always_comb begin
      hdr_d   = hdr_q;
      go_ctrl = 1'b0;

      if (hdr_q.phase == PH_DEST || hdr_q.phase == PH_SRC || hdr_q.phase == PH_DIGI) begin
         if (addr_last) begin
            hdr_d.field_idx  = 3'd0;
            hdr_d.space_seen = 1'b0;
         end else begin
            hdr_d.field_idx  = hdr_q.field_idx + 3'd1;
            hdr_d.space_seen = space_now;
         end
      end

      unique case (hdr_q.phase)
         PH_DEST: begin
            if (addr_last) begin
               hdr_d.dest_ssid = data_byte[4:1];
               hdr_d.phase     = PH_SRC;
            end else begin
               hdr_d.dest_call = call_out;
            end
         end
         PH_SRC: begin
            if (addr_last) begin
               hdr_d.source_ssid = data_byte[4:1];
               go_ctrl           = data_byte[0] || (hdr_q.digi_count >= MaxRep);
               hdr_d.phase       = go_ctrl ? PH_CTRL : PH_DIGI;
            end else begin
               hdr_d.source_call = call_out;
            end
         end
         PH_DIGI: begin
            if (addr_last) begin
               hdr_d.digi_count = digi_next;
               go_ctrl          = data_byte[0] || (digi_next >= MaxRep);
               hdr_d.phase      = go_ctrl ? PH_CTRL : PH_DIGI;
            end
         end
         PH_CTRL: begin
            hdr_d.control = data_byte;
            if (data_byte[1:0] == CTRL_PID_MASK) begin
               hdr_d.phase = PH_PID;
            end else begin
               hdr_d.phase         = PH_DONE;
               hdr_d.header_done   = 1'b1;
               hdr_d.header_length = byte_count + 9'd1;
            end
         end
         PH_PID: begin
            hdr_d.pid           = data_byte;
            hdr_d.phase         = PH_DONE;
            hdr_d.header_done   = 1'b1;
            hdr_d.header_length = byte_count + 9'd1;
         end
         default: begin
            hdr_d = hdr_q;
         end
      endcase
   end

endmodule

// ----- rtl/core/ax25_frame_parser_fcs.sv -----
// ----------------------------------------------------------------------------
// ax25_frame_parser_fcs: streaming AX.25 frame parser with FCS check
// The block takes one deflagged frame as a start request, a run of byte
// requests and an end request. A new request may follow in every cycle: one
// register stage holds the frame state and the result, so the rate is one
// request per clock whenever the result side keeps up. A result waits in the
// output register while the next request is taken, provided the waiting
// result leaves in that same cycle. Info field bytes come out in order,
// delayed by two bytes so the trailing FCS never appears as info. The end
// request produces a report with the status (valid, too short, header
// truncated or FCS mismatch) and, for valid and mismatch reports, the decoded
// callsigns, SSIDs, repeater count, control and PID bytes, info length and
// the received FCS. Bytes outside a frame and unknown request codes are
// dropped without a result; a frame that outgrows MAX_FRAME_BYTES stops
// taking bytes but is still judged at end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ax25_frame_parser_fcs #(
   parameter int MAX_FRAME_BYTES = afp_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MIN_FRAME_BYTES = afp_pkg::MIN_FRAME_BYTES_DEF,
   parameter int MAX_REPEATERS   = afp_pkg::MAX_REPEATERS_DEF
) (
   input logic      clock,
   input logic      reset,
   afp_req_if.sink  req_chan,
   afp_rsp_if.source rsp_chan
);
   import afp_pkg::*;

   localparam logic [8:0] MaxBytes = 9'(MAX_FRAME_BYTES);
   localparam logic [8:0] MinBytes = 9'(MIN_FRAME_BYTES);

   // Frame state.
   logic        receiving_ff, receiving_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  delay0_ff, delay0_in;
   logic [7:0]  delay1_ff, delay1_in;
   afp_hdr_type hdr_ff, hdr_in;
   afp_hdr_type hdr_parsed;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  info_byte_ff, info_byte_in;
   logic [1:0]  status_ff, status_in;
   logic [47:0] dest_call_ff, dest_call_in;
   logic [3:0]  dest_ssid_ff, dest_ssid_in;
   logic [47:0] source_call_ff, source_call_in;
   logic [3:0]  source_ssid_ff, source_ssid_in;
   logic [3:0]  digi_count_ff, digi_count_in;
   logic [7:0]  control_ff, control_in;
   logic [7:0]  pid_ff, pid_in;
   logic [8:0]  info_length_ff, info_length_in;
   logic [15:0] fcs_ff, fcs_in;

   logic        req_accept;
   logic        has_result;
   logic [15:0] fcs_rx;
   afp_op_type  req_op;

   // A request is taken when the result register is empty or drains this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_op         = afp_op_type'(req_chan.op);
   assign fcs_rx         = {delay1_ff, delay0_ff};

   afp_hdr_parse #(
      .MAX_REPEATERS(MAX_REPEATERS)
   ) u_hdr_parse (
      .hdr_q     (hdr_ff),
      .data_byte (req_chan.data_byte),
      .byte_count(byte_count_ff),
      .hdr_d     (hdr_parsed)
   );

   always_comb begin
      receiving_in  = receiving_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      delay0_in     = delay0_ff;
      delay1_in     = delay1_ff;
      hdr_in        = hdr_ff;

      has_result     = 1'b0;
      kind_in        = KIND_INFO;
      info_byte_in   = 8'd0;
      status_in      = STAT_VALID;
      dest_call_in   = 48'd0;
      dest_ssid_in   = 4'd0;
      source_call_in = 48'd0;
      source_ssid_in = 4'd0;
      digi_count_in  = 4'd0;
      control_in     = 8'd0;
      pid_in         = 8'd0;
      info_length_in = 9'd0;
      fcs_in         = 16'd0;

      if (req_accept) begin
         unique case (req_op)
            OP_START: begin
               // A start inside a frame abandons it.
               receiving_in  = 1'b1;
               byte_count_in = 9'd0;
               crc_in        = CRC_INIT;
               delay0_in     = 8'd0;
               delay1_in     = 8'd0;
               hdr_in        = HDR_CLEAR;
            end
            OP_BYTE: begin
               if (receiving_ff) begin
                  if (byte_count_ff >= MaxBytes) begin
                     // Overlong frame: drop the byte and stop listening.
                     receiving_in = 1'b0;
                  end else begin
                     hdr_in = hdr_parsed;
                     if (byte_count_ff >= 9'd2) begin
                        // The byte leaving the delay line is now known not to be FCS.
                        crc_in = crc16_feed(crc_ff, delay0_ff);
                        if (hdr_parsed.header_done &&
                            (byte_count_ff - 9'd2) >= hdr_parsed.header_length) begin
                           has_result   = 1'b1;
                           kind_in      = KIND_INFO;
                           info_byte_in = delay0_ff;
                        end
                     end
                     delay0_in     = delay1_ff;
                     delay1_in     = req_chan.data_byte;
                     byte_count_in = byte_count_ff + 9'd1;
                  end
               end
            end
            OP_END: begin
               // The state is left as is, so a repeated end reports again.
               receiving_in = 1'b0;
               has_result   = 1'b1;
               kind_in      = KIND_REPORT;
               if (byte_count_ff < MinBytes) begin
                  status_in = STAT_SHORT;
               end else if (!hdr_ff.header_done ||
                            ({1'b0, hdr_ff.header_length} + 10'd2) >
                            {1'b0, byte_count_ff}) begin
                  status_in = STAT_TRUNCATED;
               end else begin
                  status_in      = ((crc_ff ^ CRC_XOROUT) == fcs_rx) ? STAT_VALID
                                                                     : STAT_FCS_BAD;
                  dest_call_in   = hdr_ff.dest_call;
                  dest_ssid_in   = hdr_ff.dest_ssid;
                  source_call_in = hdr_ff.source_call;
                  source_ssid_in = hdr_ff.source_ssid;
                  digi_count_in  = hdr_ff.digi_count;
                  control_in     = hdr_ff.control;
                  pid_in         = hdr_ff.pid;
                  info_length_in = byte_count_ff - hdr_ff.header_length - 9'd2;
                  fcs_in         = fcs_rx;
               end
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end

      if (req_accept && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff  <= 1'b0;
         byte_count_ff <= 9'd0;
         crc_ff        <= CRC_INIT;
         delay0_ff     <= 8'd0;
         delay1_ff     <= 8'd0;
         hdr_ff        <= HDR_CLEAR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         receiving_ff  <= receiving_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         delay0_ff     <= delay0_in;
         delay1_ff     <= delay1_in;
         hdr_ff        <= hdr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload loads only when a new result is produced.
   always_ff @(posedge clock) begin
      if (req_accept && has_result) begin
         kind_ff        <= kind_in;
         info_byte_ff   <= info_byte_in;
         status_ff      <= status_in;
         dest_call_ff   <= dest_call_in;
         dest_ssid_ff   <= dest_ssid_in;
         source_call_ff <= source_call_in;
         source_ssid_ff <= source_ssid_in;
         digi_count_ff  <= digi_count_in;
         control_ff     <= control_in;
         pid_ff         <= pid_in;
         info_length_ff <= info_length_in;
         fcs_ff         <= fcs_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.kind             = kind_ff;
   assign rsp_chan.info_byte        = info_byte_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.dest_callsign    = dest_call_ff;
   assign rsp_chan.dest_ssid        = dest_ssid_ff;
   assign rsp_chan.source_callsign  = source_call_ff;
   assign rsp_chan.source_ssid      = source_ssid_ff;
   assign rsp_chan.digipeater_count = digi_count_ff;
   assign rsp_chan.control_byte     = control_ff;
   assign rsp_chan.pid_byte         = pid_ff;
   assign rsp_chan.info_length      = info_length_ff;
   assign rsp_chan.received_fcs     = fcs_ff;

`ifndef SYNTHESIS
   // The byte counter never runs past the frame limit.
   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= MaxBytes)
      else $error("byte count beyond frame limit");

   // The repeater count never exceeds its limit.
   assert property (@(posedge clock) disable iff (reset)
      hdr_ff.digi_count <= 4'(MAX_REPEATERS))
      else $error("repeater count beyond limit");

   // The header is complete exactly when the decoder has reached its last phase.
   assert property (@(posedge clock) disable iff (reset)
      hdr_ff.header_done == (hdr_ff.phase == PH_DONE))
      else $error("header done flag out of step with decode phase");

   // An info byte is only ever produced once the header has been decoded.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && has_result && kind_in == KIND_INFO) |=> hdr_ff.header_done)
      else $error("info byte produced before header completed");
`endif

endmodule
